/* hw/rtl/smis_pkg.sv */
// Package for the slack-maximising insertion scheduler.
// Holds sizes, time and slack types, the job record and the beat payloads.
// No dependencies.
package smis_pkg;

    localparam int MAX_JOBS  = 64;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int TOT_W     = TIME_BITS + CNT_W + 1;

    typedef logic [TIME_BITS-1:0]        t_time;
    typedef logic signed [TIME_BITS:0]   t_slk;
    typedef logic signed [TOT_W-1:0]     t_tot;
    typedef logic [CNT_W-1:0]            t_cnt;
    typedef logic [IDX_W-1:0]            t_idx;

    typedef enum logic {
        FUNC_TRY     = 1'b0,
        FUNC_PERFORM = 1'b1
    } t_func;

    typedef struct packed {
        t_time arrival;
        t_time deadline;
        t_time start;
        t_time stop;
    } t_job;

    typedef struct packed {
        t_func func;
        t_time arrival;
        t_time deadline;
        t_time duration;
        t_time start_time;
        t_time end_time;
    } t_in_beat;

    typedef struct packed {
        t_time out_arrival;
        t_time out_deadline;
        t_time out_start;
        t_time out_end;
        logic  fail;
        t_cnt  job_count;
    } t_out_beat;

    // run time of a stored job, zero when it ends before it starts
    function automatic t_time jdur(input t_job j);
        jdur = (j.stop >= j.start) ? t_time'(j.stop - j.start) : '0;
    endfunction

endpackage

/* hw/rtl/smis_if.sv */
// Valid/ready channel interfaces for the scheduler's input and result beats.
// Depends on smis_pkg.
interface smis_in_if;
    logic               valid;
    logic               ready;
    smis_pkg::t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface smis_out_if;
    logic                valid;
    logic                ready;
    smis_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/smis_tunit.sv */
// Shared time unit: saturating max(a, b) + d and the slack dl - result.
// Depends on smis_pkg.
module smis_tunit (
    input  smis_pkg::t_time i_a,
    input  smis_pkg::t_time i_b,
    input  smis_pkg::t_time i_d,
    input  smis_pkg::t_time i_dl,
    output smis_pkg::t_time o_sum,
    output smis_pkg::t_slk  o_slk
);
    import smis_pkg::*;

    t_time                mx;
    logic [TIME_BITS:0]   raw;

    assign mx    = (i_a > i_b) ? i_a : i_b;
    assign raw   = {1'b0, mx} + {1'b0, i_d};
    assign o_sum = raw[TIME_BITS] ? '1 : raw[TIME_BITS-1:0];
    assign o_slk = $signed({1'b0, i_dl}) - $signed({1'b0, o_sum});

endmodule

/* hw/rtl/slack_max_insertion_scheduler.sv */
// Top level of the slack-maximising insertion scheduler: sequencer, job table, result register.
// Depends on smis_pkg, smis_if and smis_tunit.
//
//   channel  | dir | beat
//   i_in     | in  | func, arrival, deadline, duration, start_time, end_time
//   o_out    | out | out_arrival, out_deadline, out_start, out_end, fail, job_count
//
// Try: scans the table up to the first job ending after arrival, then for each insertion
// point i re-times the new job and every stored job from i to the end of the table.
// Perform: scan for the position, shift later jobs up, write the job, push overlapping ones.
// Every step goes through the one time unit and the table's single read port.
// Reset clears only the state, count and result valid; table entries are valid below count.
// i_in.ready is low while an item is worked on or its result beat waits.
module slack_max_insertion_scheduler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smis_in_if.sink         i_in,
    smis_out_if.source      o_out
);
    import smis_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SCAN_RD = 14'b00000000000010,
        S_SCAN_EV = 14'b00000000000100,
        S_TRY_PT  = 14'b00000000001000,
        S_IN_RD   = 14'b00000000010000,
        S_TS_EV   = 14'b00000000100000,
        S_IN_EV   = 14'b00000001000000,
        S_TRY_CMP = 14'b00000010000000,
        S_TRY_FIN = 14'b00000100000000,
        S_SH_RD   = 14'b00001000000000,
        S_SH_WR   = 14'b00010000000000,
        S_INS_WR  = 14'b00100000000000,
        S_CH_RD   = 14'b01000000000000,
        S_CH_EV   = 14'b10000000000000
    } t_state;

    t_job   mem [MAX_JOBS];
    t_job   r_rdata;
    t_idx   rd_addr;
    logic   we;
    t_idx   wr_addr;
    t_job   wr_data;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_ovalid, n_ovalid;
    t_func  r_func, n_func;
    t_time  r_arr, n_arr, r_dl, n_dl, r_dur, n_dur, r_st, n_st, r_en, n_en;
    t_time  r_o_dl, n_o_dl, r_o_start, n_o_start, r_o_end, n_o_end;
    logic   r_o_fail, n_o_fail;
    t_cnt   r_k, n_k, r_i, n_i, r_pos, n_pos;
    t_time  r_tstart, n_tstart, r_t, n_t, r_tsched, n_tsched, r_best, n_best;
    t_slk   r_ins, n_ins, r_maxins, n_maxins;
    t_tot   r_tot, n_tot, r_maxtot, n_maxtot;
    logic   r_found, n_found, r_none, n_none;

    t_time  u_a, u_b, u_d, u_dl, u_sum;
    t_slk   u_slk;
    t_time  key;
    logic   better;

    smis_tunit u_tunit (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_d   (u_d),
        .i_dl  (u_dl),
        .o_sum (u_sum),
        .o_slk (u_slk)
    );

    assign i_in.ready                = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid               = r_ovalid;
    assign o_out.payload.out_arrival = r_arr;
    assign o_out.payload.out_deadline= r_o_dl;
    assign o_out.payload.out_start   = r_o_start;
    assign o_out.payload.out_end     = r_o_end;
    assign o_out.payload.fail        = r_o_fail;
    assign o_out.payload.job_count   = r_count;

    assign key     = (r_func == FUNC_TRY) ? r_arr : r_st;
    assign rd_addr = (r_state == S_SH_RD) ? t_idx'(r_i - t_cnt'(1)) : r_k[IDX_W-1:0];

    always_comb begin
        u_a  = r_t;
        u_b  = r_t;
        u_d  = jdur(r_rdata);
        u_dl = r_rdata.deadline;
        unique case (r_state)
            S_TRY_PT: begin
                u_a  = r_tstart;
                u_b  = r_arr;
                u_d  = r_dur;
                u_dl = r_dl;
            end
            S_TS_EV: begin
                u_a = r_tstart;
                u_b = r_rdata.arrival;
            end
            S_IN_EV: begin
                u_b = r_rdata.arrival;
            end
            S_TRY_FIN: begin
                u_a = r_none ? r_arr : r_best;
                u_b = u_a;
                u_d = r_dur;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        better = !r_found || (r_tot > r_maxtot);
        if (r_found && r_maxins[TIME_BITS]) begin
            if (r_ins < r_maxins) better = 1'b0;
            if (r_ins > r_maxins) better = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_ovalid = r_ovalid;
        n_func = r_func;     n_arr = r_arr;       n_dl = r_dl;
        n_dur = r_dur;       n_st = r_st;         n_en = r_en;
        n_o_dl = r_o_dl;     n_o_start = r_o_start;
        n_o_end = r_o_end;   n_o_fail = r_o_fail;
        n_k = r_k;           n_i = r_i;           n_pos = r_pos;
        n_tstart = r_tstart; n_t = r_t;           n_tsched = r_tsched;
        n_best = r_best;     n_ins = r_ins;       n_maxins = r_maxins;
        n_tot = r_tot;       n_maxtot = r_maxtot;
        n_found = r_found;   n_none = r_none;
        we      = 1'b0;
        wr_addr = r_k[IDX_W-1:0];
        wr_data = r_rdata;

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_func    = i_in.payload.func;
                    n_arr     = i_in.payload.arrival;
                    n_dl      = i_in.payload.deadline;
                    n_dur     = i_in.payload.duration;
                    n_st      = i_in.payload.start_time;
                    n_en      = i_in.payload.end_time;
                    n_o_dl    = i_in.payload.deadline;
                    n_o_start = i_in.payload.start_time;
                    n_o_end   = i_in.payload.end_time;
                    n_o_fail  = 1'b0;
                    n_k       = '0;
                    n_tstart  = '0;
                    n_found   = 1'b0;
                    n_none    = 1'b0;
                    if (i_in.payload.func == FUNC_PERFORM && r_count >= t_cnt'(MAX_JOBS)) begin
                        n_o_fail = 1'b1;
                        n_ovalid = 1'b1;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_k == r_count) begin
                    if (r_func == FUNC_TRY) begin
                        n_none  = 1'b1;
                        n_state = S_TRY_FIN;
                    end else begin
                        n_pos   = r_count;
                        n_i     = r_count;
                        n_state = S_SH_RD;
                    end
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (key < r_rdata.stop) begin
                    n_pos   = r_k;
                    n_i     = (r_func == FUNC_TRY) ? r_k : r_count;
                    n_state = (r_func == FUNC_TRY) ? S_TRY_PT : S_SH_RD;
                end else begin
                    n_tstart = r_rdata.stop;
                    n_k      = r_k + t_cnt'(1);
                    n_state  = S_SCAN_RD;
                end
            end
            S_TRY_PT: begin
                if (r_i == r_count) begin
                    n_state = S_TRY_FIN;
                end else if (r_found && !r_maxins[TIME_BITS] && r_maxins != t_slk'(0)
                             && u_slk[TIME_BITS]) begin
                    n_state = S_TRY_FIN;
                end else begin
                    n_tsched = u_sum;
                    n_t      = u_sum;
                    n_ins    = u_slk;
                    n_tot    = t_tot'(u_slk);
                    n_k      = r_i;
                    n_state  = S_IN_RD;
                end
            end
            S_IN_RD: begin
                if (r_k == r_count) n_state = S_TRY_CMP;
                else if (r_k == r_i) n_state = S_TS_EV;
                else n_state = S_IN_EV;
            end
            S_TS_EV: begin
                n_tstart = u_sum;
                n_state  = S_IN_EV;
            end
            S_IN_EV: begin
                if (u_slk[TIME_BITS]) begin
                    n_i     = r_i + t_cnt'(1);
                    n_state = S_TRY_PT;
                end else begin
                    n_t     = u_sum;
                    n_tot   = r_tot + t_tot'(u_slk);
                    n_k     = r_k + t_cnt'(1);
                    n_state = S_IN_RD;
                end
            end
            S_TRY_CMP: begin
                if (better) begin
                    n_maxins = r_ins;
                    n_maxtot = r_tot;
                    n_best   = r_tsched;
                    n_found  = 1'b1;
                end
                n_i     = r_i + t_cnt'(1);
                n_state = S_TRY_PT;
            end
            S_TRY_FIN: begin
                if (r_none) begin
                    n_o_start = r_arr;
                    n_o_end   = u_sum;
                end else if (r_found) begin
                    n_o_start = r_best;
                    n_o_end   = u_sum;
                    n_o_dl    = (u_sum > r_dl) ? u_sum : r_dl;
                end else begin
                    n_o_start = '0;
                    n_o_end   = '0;
                    n_o_fail  = 1'b1;
                end
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_SH_RD: begin
                n_state = (r_i == r_pos) ? S_INS_WR : S_SH_WR;
            end
            S_SH_WR: begin
                we      = 1'b1;
                wr_addr = r_i[IDX_W-1:0];
                n_i     = r_i - t_cnt'(1);
                n_state = S_SH_RD;
            end
            S_INS_WR: begin
                we      = 1'b1;
                wr_addr = r_pos[IDX_W-1:0];
                wr_data = '{arrival: r_arr, deadline: r_dl, start: r_st, stop: r_en};
                n_count = r_count + t_cnt'(1);
                n_t     = r_en;
                n_k     = r_pos + t_cnt'(1);
                n_state = S_CH_RD;
            end
            S_CH_RD: begin
                if (r_k == r_count) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CH_EV;
                end
            end
            S_CH_EV: begin
                if (r_t < r_rdata.start) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    we      = 1'b1;
                    wr_data = '{arrival: r_rdata.arrival, deadline: r_rdata.deadline,
                                start: r_t, stop: u_sum};
                    n_t     = u_sum;
                    n_k     = r_k + t_cnt'(1);
                    n_state = S_CH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;     r_arr <= n_arr;       r_dl <= n_dl;
        r_dur <= n_dur;       r_st <= n_st;         r_en <= n_en;
        r_o_dl <= n_o_dl;     r_o_start <= n_o_start;
        r_o_end <= n_o_end;   r_o_fail <= n_o_fail;
        r_k <= n_k;           r_i <= n_i;           r_pos <= n_pos;
        r_tstart <= n_tstart; r_t <= n_t;           r_tsched <= n_tsched;
        r_best <= n_best;     r_ins <= n_ins;       r_maxins <= n_maxins;
        r_tot <= n_tot;       r_maxtot <= n_maxtot;
        r_found <= n_found;   r_none <= n_none;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_JOBS))
        else $error("job count beyond table size");

    a_busy_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid)
        else $error("result beat shown while still working");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("job count moved by other than one");

    a_try_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_func == FUNC_TRY && r_o_fail) |-> (r_o_start == '0 && r_o_end == '0))
        else $error("failed try carries a slot");

endmodule

/* verif/tb.sv */
// Testbench for slack_max_insertion_scheduler: directed and random try/perform beats.
// An in-file scoreboard class predicts each result and checks the result beats in order.
// Depends on smis_pkg, smis_if and slack_max_insertion_scheduler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smis_pkg::*;

    localparam longint unsigned TMAX = (64'd1 << TIME_BITS) - 1;
    localparam longint SMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    class sched_scoreboard;
        longint unsigned arr_q[MAX_JOBS], dl_q[MAX_JOBS], st_q[MAX_JOBS], en_q[MAX_JOBS];
        int unsigned     njobs;
        t_out_beat       pending[$];
        int              errors;

        function longint unsigned tadd(longint unsigned a, longint unsigned b);
            return (a + b > TMAX) ? TMAX : a + b;
        endfunction

        function longint unsigned tmax(longint unsigned a, longint unsigned b);
            return a > b ? a : b;
        endfunction

        function longint unsigned run_len(int unsigned i);
            return en_q[i] >= st_q[i] ? en_q[i] - st_q[i] : 0;
        endfunction

        function longint slk(longint unsigned d, longint unsigned t);
            return longint'(d) - longint'(t);
        endfunction

        function void note_beat(t_in_beat b);
            t_out_beat       r;
            longint unsigned a, d, du, s, e, tstart, best, tsch, t;
            longint          maxtot, maxins, ins, tot, js;
            int unsigned     first, pos;
            bit              found, ok, better;
            a = 64'(b.arrival); d = 64'(b.deadline); du = 64'(b.duration);
            s = 64'(b.start_time); e = 64'(b.end_time);
            r = '0;
            r.out_arrival = t_time'(a);
            r.out_deadline = t_time'(d);
            if (b.func == FUNC_TRY) begin
                first = 0;
                while (first < njobs && !(a < en_q[first])) first++;
                if (first == njobs) begin
                    r.out_start = t_time'(a);
                    r.out_end = t_time'(tadd(a, du));
                end else begin
                    tstart = first > 0 ? en_q[first-1] : 0;
                    found = 0; best = 0; maxtot = -1; maxins = SMIN;
                    for (int unsigned i = first; i < njobs; i++) begin
                        tsch = tadd(tmax(tstart, a), du);
                        t = tsch;
                        ins = slk(d, tsch);
                        tot = ins;
                        ok = 1;
                        if (maxins > 0 && ins < 0) break;
                        tstart = tadd(tmax(tstart, arr_q[i]), run_len(i));
                        for (int unsigned k = i; k < njobs; k++) begin
                            t = tadd(tmax(t, arr_q[k]), run_len(k));
                            js = slk(dl_q[k], t);
                            if (js < 0) begin
                                ok = 0;
                                break;
                            end
                            tot = (tot > SMAX - js) ? SMAX : tot + js;
                        end
                        if (!ok) continue;
                        better = tot > maxtot;
                        if (maxins < 0) begin
                            if (ins < maxins) better = 0;
                            if (ins > maxins) better = 1;
                        end
                        if (better) begin
                            maxins = ins; maxtot = tot; best = tsch; found = 1;
                        end
                    end
                    if (found) begin
                        r.out_end = t_time'(tadd(best, du));
                        r.out_start = t_time'(best);
                        r.out_deadline = t_time'(tmax(d, tadd(best, du)));
                    end else begin
                        r.fail = 1'b1;
                    end
                end
            end else begin
                r.out_start = t_time'(s);
                r.out_end = t_time'(e);
                if (njobs >= MAX_JOBS) begin
                    r.fail = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < njobs && !(s < en_q[pos])) pos++;
                    for (int unsigned i = njobs; i > pos; i--) begin
                        arr_q[i] = arr_q[i-1]; dl_q[i] = dl_q[i-1];
                        st_q[i] = st_q[i-1]; en_q[i] = en_q[i-1];
                    end
                    arr_q[pos] = a; dl_q[pos] = d; st_q[pos] = s; en_q[pos] = e;
                    njobs++;
                    t = e;
                    for (int unsigned i = pos + 1; i < njobs; i++) begin
                        if (t < st_q[i]) break;
                        en_q[i] = tadd(t, run_len(i));
                        st_q[i] = t;
                        t = en_q[i];
                    end
                end
            end
            r.job_count = t_cnt'(njobs);
            pending.push_back(r);
        endfunction

        function void field(string nm, longint unsigned x, longint unsigned y);
            if (x != y) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, nm, x, y);
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat x;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected", $time);
                return;
            end
            x = pending.pop_front();
            field("out_arrival", 64'(x.out_arrival), 64'(got.out_arrival));
            field("out_deadline", 64'(x.out_deadline), 64'(got.out_deadline));
            field("out_start", 64'(x.out_start), 64'(got.out_start));
            field("out_end", 64'(x.out_end), 64'(got.out_end));
            field("fail", 64'(x.fail), 64'(got.fail));
            field("job_count", 64'(x.job_count), 64'(got.job_count));
        endfunction
    endclass

    logic i_clk, i_rst_n;
    smis_in_if  in_ch();
    smis_out_if out_ch();

    slack_max_insertion_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    sched_scoreboard sched_sb = new();
    int  hold_left = 0;
    bit  rx_busy_mode = 1;
    longint unsigned horizon = 1000;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    initial begin
        #100ms;
        $display("slack_max_insertion_scheduler verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) sched_sb.note_beat(in_ch.payload);
        if (i_rst_n && out_ch.valid && out_ch.ready) sched_sb.check_result(out_ch.payload);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random back-pressure, plus a long hold when requested
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!rx_busy_mode) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) < 70);
                if ($urandom_range(0, 99) < 4) hold_left = $urandom_range(5, 40);
            end
        end
    end

    // called at a falling edge; returns at a falling edge with the beat taken
    task automatic send_beat(input t_in_beat b);
        int g;
        g = rx_busy_mode ? pick_gap() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic try_job(input longint unsigned a, d, du);
        t_in_beat b;
        b = '0;
        b.func = FUNC_TRY; b.arrival = t_time'(a); b.deadline = t_time'(d);
        b.duration = t_time'(du);
        b.start_time = $urandom; b.end_time = $urandom;
        send_beat(b);
    endtask

    task automatic perform_job(input longint unsigned a, d, s, e);
        t_in_beat b;
        b = '0;
        b.func = FUNC_PERFORM; b.arrival = t_time'(a); b.deadline = t_time'(d);
        b.start_time = t_time'(s); b.end_time = t_time'(e); b.duration = $urandom;
        send_beat(b);
    endtask

    task automatic random_beat();
        longint unsigned a, s, du;
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) try_job($urandom, $urandom, $urandom);
            else perform_job($urandom, $urandom, $urandom, $urandom);
        end else if ($urandom_range(0, 1)) begin
            s = horizon > 30 ? horizon - $urandom_range(0, 30) : horizon;
            du = $urandom_range(1, 40);
            a = s > 20 ? s - $urandom_range(0, 20) : s;
            perform_job(a, s + du + $urandom_range(0, 150), s, s + du);
            if (s + du > horizon) horizon = s + du;
        end else begin
            a = $urandom_range(0, int'(horizon));
            du = $urandom_range(0, 50);
            try_job(a, a + du + $urandom_range(0, 250), du);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, saturation, pushes, infeasible, negative duration
        try_job(0, 0, 0);
        try_job(TMAX, TMAX, TMAX);
        try_job(100, 50, 20);
        perform_job(0, 200, 100, 150);
        perform_job(10, 300, 120, 180);
        perform_job(0, 400, 300, 250);
        try_job(50, 500, 30);
        try_job(160, 165, 10);
        try_job(0, 0, 1000);
        try_job(0, TMAX, 5);
        try_job(140, 190, 40);
        perform_job(TMAX, TMAX, TMAX - 5, TMAX);
        try_job(TMAX, 0, TMAX);
        try_job(0, TMAX, TMAX);
        perform_job(5, 90, 0, 60);
        try_job(1, 2, 0);
        try_job(400, 600, 10);
        perform_job(TMAX, 0, 0, TMAX);
        try_job(20, 1000, 1);

        // back-pressure: receiver stalls while the sender keeps offering
        hold_left = 400;
        repeat (6) random_beat();
        for (int i = 0; i < 120; i++) begin
            rx_busy_mode = (i % 40) < 30;
            random_beat();
        end
        in_ch.valid <= 1'b0;
        rx_busy_mode = 1'b0;

        while (sched_sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sched_sb.errors == 0) begin
            $display("slack_max_insertion_scheduler verification clean");
        end else begin
            $display("slack_max_insertion_scheduler verification failed");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/smis_pkg.sv
hw/rtl/smis_if.sv
hw/rtl/smis_tunit.sv
hw/rtl/slack_max_insertion_scheduler.sv
verif/tb.sv
